[hw/rtl/ccud_pkg.sv]
// ----------------------------------------------------------------------------
// ccud_pkg
// shared types and constants of the closed caption user data parser
// ----------------------------------------------------------------------------
package ccud_pkg;

  localparam logic [23:0] TAG_HEAD   = 24'h474139;
  localparam logic [7:0]  TAG_LAST   = 8'h34;
  localparam logic [4:0]  COUNT_MASK = 5'h1f;

  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic        item_kind;
    logic [1:0]  caption_type;
    logic [15:0] caption_word;
    logic [7:0]  valid_total;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[hw/rtl/ccud_parser.sv]
// ----------------------------------------------------------------------------
// ccud_parser
// per-byte tag hunt and cc_data triplet parse, up to two results per beat
// ----------------------------------------------------------------------------
module ccud_parser import ccud_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_payload,
  output push_t      push
);

  localparam logic [2:0] PH_HUNT      = 3'd0;
  localparam logic [2:0] PH_SKIP_TYPE = 3'd1;
  localparam logic [2:0] PH_FLAGS     = 3'd2;
  localparam logic [2:0] PH_SKIP_EM   = 3'd3;
  localparam logic [2:0] PH_TRIPLETS  = 3'd4;

  logic [23:0] tag_window, tag_window_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [4:0]  triplets_left, triplets_left_next;
  logic [1:0]  triplet_position, triplet_position_next;
  logic [2:0]  held_valid_and_type, held_valid_and_type_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic [7:0]  pair_total, pair_total_next;
  logic        pair_emit;
  result_t     pair_res, sum_res;

  always_comb begin
    tag_window_next          = tag_window;
    parse_phase_next         = parse_phase;
    triplets_left_next       = triplets_left;
    triplet_position_next    = triplet_position;
    held_valid_and_type_next = held_valid_and_type;
    held_low_byte_next       = held_low_byte;
    pair_total_next          = pair_total;
    pair_emit                = 1'b0;
    case (parse_phase)
      PH_SKIP_TYPE: begin
        parse_phase_next = PH_FLAGS;
      end
      PH_FLAGS: begin
        if (data_byte[6]) begin
          triplets_left_next = data_byte[4:0] & COUNT_MASK;
          parse_phase_next   = PH_SKIP_EM;
        end else begin
          // window cleared, then this byte starts a new hunt
          parse_phase_next = PH_HUNT;
          tag_window_next  = {16'h0000, data_byte};
        end
      end
      PH_SKIP_EM: begin
        triplet_position_next = 2'd0;
        parse_phase_next      = (triplets_left != 5'd0) ? PH_TRIPLETS : PH_HUNT;
        tag_window_next       = 24'h000000;
      end
      PH_TRIPLETS: begin
        if (triplet_position == 2'd0) begin
          held_valid_and_type_next = data_byte[2:0];
          triplet_position_next    = 2'd1;
        end else if (triplet_position == 2'd1) begin
          held_low_byte_next    = data_byte;
          triplet_position_next = 2'd2;
        end else begin
          if (held_valid_and_type[2]) begin
            pair_emit = 1'b1;
            if (pair_total != 8'hff) begin
              pair_total_next = pair_total + 8'd1;
            end
          end
          triplet_position_next = 2'd0;
          triplets_left_next    = triplets_left - 5'd1;
          if (triplets_left == 5'd1) begin
            parse_phase_next = PH_HUNT;
            tag_window_next  = 24'h000000;
          end
        end
      end
      default: begin
        parse_phase_next = PH_HUNT;
        if (tag_window == TAG_HEAD && data_byte == TAG_LAST) begin
          tag_window_next  = 24'h000000;
          parse_phase_next = PH_SKIP_TYPE;
        end else begin
          tag_window_next = {tag_window[15:0], data_byte};
        end
      end
    endcase

    pair_res.item_kind    = KIND_PAIR;
    pair_res.caption_type = held_valid_and_type[1:0];
    pair_res.caption_word = {data_byte, held_low_byte};
    pair_res.valid_total  = pair_total_next;
    pair_res.last_result  = ~end_of_payload;

    sum_res.item_kind    = KIND_SUMMARY;
    sum_res.caption_type = 2'd0;
    sum_res.caption_word = 16'h0000;
    sum_res.valid_total  = pair_total_next;
    sum_res.last_result  = 1'b1;

    push.first  = pair_emit ? pair_res : sum_res;
    push.second = sum_res;
    push.count  = 2'd0;
    if (accept) begin
      push.count = {1'b0, pair_emit} + {1'b0, end_of_payload};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_payload)) begin
      tag_window          <= 24'h000000;
      parse_phase         <= PH_HUNT;
      triplets_left       <= 5'd0;
      triplet_position    <= 2'd0;
      held_valid_and_type <= 3'd0;
      held_low_byte       <= 8'h00;
      pair_total          <= 8'h00;
    end else if (accept) begin
      tag_window          <= tag_window_next;
      parse_phase         <= parse_phase_next;
      triplets_left       <= triplets_left_next;
      triplet_position    <= triplet_position_next;
      held_valid_and_type <= held_valid_and_type_next;
      held_low_byte       <= held_low_byte_next;
      pair_total          <= pair_total_next;
    end
  end

endmodule

[hw/rtl/ccud_result_fifo.sv]
// ----------------------------------------------------------------------------
// ccud_result_fifo
// small result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
module ccud_result_fifo import ccud_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/closed_caption_user_data_parser_unit.sv]
// ----------------------------------------------------------------------------
// closed_caption_user_data_parser_unit
// GA94 cc_data parser for video user data, one byte per beat
// ----------------------------------------------------------------------------
// input channel: in_valid / in_ready carry data_byte and end_of_payload, one
// payload byte per beat, end_of_payload set on the final byte
// output channel: out_valid / out_ready carry one result per beat, either a
// caption pair (item_kind 0) or the end-of-payload summary (item_kind 1)
// latency: a byte's results join the queue in the cycle after it is taken
// throughput: one byte per cycle while in_ready is high; state steps per byte
// a byte can cause up to two results; they go into a four-entry queue that
// drains one per cycle while out_ready is high; in_ready drops only while
// under two slots are free, so a stalled receiver holds the input as it fills
// reset: synchronous, clears the parse state and empties the result queue;
// in_ready is high in the first cycle after reset
// ----------------------------------------------------------------------------
module closed_caption_user_data_parser_unit import ccud_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [1:0]  caption_type,
  output logic [15:0] caption_word,
  output logic [7:0]  valid_total,
  output logic        last_result
);

  push_t   push;
  result_t head;
  logic    room;

  assign in_ready = room;

  ccud_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_valid && room),
    .data_byte      (data_byte),
    .end_of_payload (end_of_payload),
    .push           (push)
  );

  ccud_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign item_kind    = head.item_kind;
  assign caption_type = head.caption_type;
  assign caption_word = head.caption_word;
  assign valid_total  = head.valid_total;
  assign last_result  = head.last_result;

endmodule
